// ===== sv/ert_pkg.sv =====
// Shared types, constants and divide step for the epoch-to-timestamp-text block.
package ert_pkg;

   localparam int unsigned NsWidth   = 64;
   localparam int unsigned CharBits  = 8;
   localparam int unsigned TextLen   = 30;
   localparam int unsigned TextBits  = TextLen * CharBits;

   localparam logic [29:0] NANOS_PER_SECOND = 30'd1000000000;
   localparam logic [29:0] SEC_PER_DAY      = 30'd86400;

   typedef struct packed {
      logic [17:0] days;
      logic [16:0] tod;
      logic [29:0] frac;
   } split_type;

   typedef struct packed {
      logic [29:0] rem;
      logic [2:0]  quo;
   } div_type;

   // Three restoring divide steps; rem must stay below dvsr.
   function automatic div_type div_step3(logic [29:0] rem, logic [2:0] bits,
                                         logic [29:0] dvsr);
      div_type     res;
      logic [30:0] r;
      int          i;
      res.rem = rem;
      res.quo = '0;
      for (i = 2; i >= 0; i--) begin
         r = {res.rem, bits[i]};
         if (r >= {1'b0, dvsr}) begin
            r          = r - {1'b0, dvsr};
            res.quo[i] = 1'b1;
         end
         res.rem = r[29:0];
      end
      return res;
   endfunction

endpackage

// ===== sv/ert_split.sv =====
// Front end: accept a nanosecond count, split it into days, time of day and fraction.
module ert_split import ert_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [NsWidth-1:0]  req_epoch_nanoseconds,
   output logic                out_valid,
   input  logic                out_ready,
   output split_type           out_item
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_NSDIV  = 2'd1;
   localparam logic [1:0] ST_SECDIV = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   localparam logic [3:0] NS_LAST  = 4'd11;
   localparam logic [3:0] SEC_LAST = 4'd6;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [29:0] rem_ff, rem_in;
   logic [35:0] sh_ff, sh_in;
   split_type   item_ff, item_in;

   div_type     step;
   logic [35:0] quo;
   logic [29:0] dvsr;
   logic        take;

   assign out_valid = (state_ff == ST_DONE);
   assign req_ready = (state_ff == ST_IDLE) || (out_valid && out_ready);
   assign take      = req_valid && req_ready;
   assign out_item  = item_ff;

   always_comb begin
      dvsr     = (state_ff == ST_SECDIV) ? SEC_PER_DAY : NANOS_PER_SECOND;
      step     = div_step3(rem_ff, sh_ff[35:33], dvsr);
      quo      = {sh_ff[32:0], step.quo};
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      item_in  = item_ff;
      unique case (state_ff)
         ST_NSDIV: begin
            rem_in = step.rem;
            sh_in  = quo;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == NS_LAST) begin
               item_in.frac = step.rem;
               rem_in       = {15'd0, quo[35:21]};
               sh_in        = {quo[20:0], 15'd0};
               cnt_in       = '0;
               state_in     = ST_SECDIV;
            end
         end
         ST_SECDIV: begin
            rem_in = step.rem;
            sh_in  = quo;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == SEC_LAST) begin
               item_in.days = quo[17:0];
               item_in.tod  = step.rem[16:0];
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: ;
      endcase
      if (take) begin
         state_in = ST_NSDIV;
         cnt_in   = '0;
         rem_in   = {2'd0, req_epoch_nanoseconds[63:36]};
         sh_in    = req_epoch_nanoseconds[35:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      item_ff <= item_in;
   end

endmodule

// ===== sv/ert_fifo.sv =====
// Two-entry queue between the front end and the calendar stage.
module ert_fifo import ert_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  split_type in_item,
   output logic      out_valid,
   input  logic      out_ready,
   output split_type out_item
);

   localparam logic [1:0] FULL_COUNT = 2'd2;

   split_type  ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = ent_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) ent_ff[wr_ptr_ff] <= in_item;
   end

endmodule

// ===== sv/ert_calc.sv =====
// Back end: civil date, clock time and decimal digits, assembled into the text line.
module ert_calc import ert_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  split_type           in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [TextBits-1:0] out_text
);

   typedef struct packed {
      logic [3:0]  dig;
      logic [29:0] rest;
   } digit_type;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ERA   = 4'd1;
   localparam logic [3:0] ST_DIVA  = 4'd2;
   localparam logic [3:0] ST_YOEP  = 4'd3;
   localparam logic [3:0] ST_DIVY  = 4'd4;
   localparam logic [3:0] ST_DOY   = 4'd5;
   localparam logic [3:0] ST_MPP   = 4'd6;
   localparam logic [3:0] ST_DIVM  = 4'd7;
   localparam logic [3:0] ST_DATE  = 4'd8;
   localparam logic [3:0] ST_DIVH  = 4'd9;
   localparam logic [3:0] ST_DIVMI = 4'd10;
   localparam logic [3:0] ST_YDIG  = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   localparam logic [3:0] FRAC_DONE = 4'd9;
   localparam logic [1:0] YDIG_LAST = 2'd3;

   localparam logic [CharBits-1:0] CH_DASH  = 8'h2D;
   localparam logic [CharBits-1:0] CH_T     = 8'h54;
   localparam logic [CharBits-1:0] CH_COLON = 8'h3A;
   localparam logic [CharBits-1:0] CH_DOT   = 8'h2E;
   localparam logic [CharBits-1:0] CH_Z     = 8'h5A;

   // Leading decimal digit of v for a constant place value.
   function automatic digit_type lead_digit(logic [29:0] v, logic [29:0] unit_val);
      digit_type   res;
      logic [33:0] thr;
      logic [33:0] sub_val;
      int          k;
      res.dig = '0;
      sub_val = '0;
      for (k = 1; k <= 9; k++) begin
         thr = 34'(k) * {4'd0, unit_val};
         if ({4'd0, v} >= thr) begin
            res.dig = 4'(k);
            sub_val = thr;
         end
      end
      res.rest = v - sub_val[29:0];
      return res;
   endfunction

   // First day of year (March based) for each shifted month.
   function automatic logic [8:0] month_base(logic [3:0] mp);
      logic [8:0] res;
      case (mp)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

   function automatic logic [CharBits-1:0] dchar(logic [3:0] d);
      return {4'h3, d};
   endfunction

   function automatic logic [2*CharBits-1:0] two_chars(logic [6:0] v);
      digit_type t;
      t = lead_digit({23'd0, v}, 30'd10);
      return {dchar(t.dig), dchar(t.rest[3:0])};
   endfunction

   logic [3:0]  state_ff, state_in;
   logic [17:0] days_ff, days_in;
   logic [16:0] tod_ff, tod_in;
   logic [2:0]  era_ff, era_in;
   logic [17:0] doe_ff, doe_in;
   logic [8:0]  yoe_ff, yoe_in;
   logic [8:0]  doy_ff, doy_in;
   logic [11:0] drem_ff, drem_in;
   logic [8:0]  dsh_ff, dsh_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic [13:0] yval_ff, yval_in;
   logic [15:0] ydig_ff, ydig_in;
   logic [1:0]  ycnt_ff, ycnt_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hh_ff, hh_in;
   logic [5:0]  mi_ff, mi_in;
   logic [5:0]  ss_ff, ss_in;
   logic [29:0] fval_ff, fval_in;
   logic [35:0] fdig_ff, fdig_in;
   logic [3:0]  fcnt_ff, fcnt_in;

   logic        take;
   logic [19:0] shifted;
   logic [2:0]  era_c;
   logic [19:0] doe_w;
   logic [29:0] dvsr;
   div_type     st;
   logic [8:0]  qfull;
   logic        dlast;
   logic [2:0]  cyc_b;
   logic        cyc_c;
   logic [17:0] num;
   logic [1:0]  cent;
   logic [17:0] ybase;
   logic [17:0] doy_w;
   logic [10:0] mpn;
   logic [3:0]  mp;
   logic [3:0]  mon_c;
   logic [8:0]  day_w;
   digit_type   yld;
   digit_type   fld;

   assign out_valid = (state_ff == ST_DONE);
   assign in_ready  = (state_ff == ST_IDLE) || (out_valid && out_ready);
   assign take      = in_valid && in_ready;

   always_comb begin
      shifted = 20'(days_ff) + 20'd719468;
      era_c   = '0;
      for (int k = 1; k <= 6; k++) begin
         if (shifted >= 20'(k * 146097)) era_c = 3'(k);
      end
      doe_w = shifted - 20'(era_c) * 20'd146097;

      case (state_ff)
         ST_DIVA:  dvsr = 30'd1460;
         ST_DIVY:  dvsr = 30'd365;
         ST_DIVM:  dvsr = 30'd153;
         ST_DIVH:  dvsr = 30'd3600;
         default:  dvsr = 30'd60;
      endcase
      st    = div_step3({18'd0, drem_ff}, dsh_ff[8:6], dvsr);
      qfull = {dsh_ff[5:0], st.quo};
      dlast = ((state_ff == ST_DIVA) || (state_ff == ST_DIVY)) ? (dcnt_ff == 2'd2)
                                                               : (dcnt_ff == 2'd1);

      cyc_b = '0;
      for (int k = 1; k <= 4; k++) begin
         if (doe_ff >= 18'(k * 36524)) cyc_b = 3'(k);
      end
      cyc_c = (doe_ff >= 18'd146096);
      num   = doe_ff - 18'(dsh_ff[6:0]) + 18'(cyc_b) - 18'(cyc_c);

      cent = '0;
      for (int k = 1; k <= 3; k++) begin
         if (yoe_ff >= 9'(k * 100)) cent = 2'(k);
      end
      ybase = 18'(yoe_ff) * 18'd365 + 18'(yoe_ff[8:2]) - 18'(cent);
      doy_w = doe_ff - ybase;

      mpn   = 11'(doy_ff) * 11'd5 + 11'd2;
      mp    = dsh_ff[3:0];
      mon_c = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      day_w = doy_ff - month_base(mp) + 9'd1;

      yld = lead_digit(30'(yval_ff), 30'd1000);
      fld = lead_digit(fval_ff, 30'd100000000);
   end

   always_comb begin
      state_in = state_ff;
      days_in  = days_ff;
      tod_in   = tod_ff;
      era_in   = era_ff;
      doe_in   = doe_ff;
      yoe_in   = yoe_ff;
      doy_in   = doy_ff;
      drem_in  = drem_ff;
      dsh_in   = dsh_ff;
      dcnt_in  = dcnt_ff;
      yval_in  = yval_ff;
      ydig_in  = ydig_ff;
      ycnt_in  = ycnt_ff;
      mon_in   = mon_ff;
      day_in   = day_ff;
      hh_in    = hh_ff;
      mi_in    = mi_ff;
      ss_in    = ss_ff;
      fval_in  = fval_ff;
      fdig_in  = fdig_ff;
      fcnt_in  = fcnt_ff;

      if (fcnt_ff != FRAC_DONE) begin
         fdig_in = {fdig_ff[31:0], fld.dig};
         fval_in = 30'(fld.rest * 30'd10);
         fcnt_in = fcnt_ff + 4'd1;
      end

      unique case (state_ff)
         ST_ERA: begin
            era_in   = era_c;
            doe_in   = doe_w[17:0];
            drem_in  = 12'(doe_w[17:9]);
            dsh_in   = doe_w[8:0];
            dcnt_in  = '0;
            state_in = ST_DIVA;
         end
         ST_DIVA, ST_DIVY, ST_DIVM, ST_DIVH, ST_DIVMI: begin
            drem_in = st.rem[11:0];
            dsh_in  = qfull;
            dcnt_in = dcnt_ff + 2'd1;
            if (dlast) begin
               unique case (state_ff)
                  ST_DIVA: state_in = ST_YOEP;
                  ST_DIVY: begin
                     yoe_in   = qfull;
                     state_in = ST_DOY;
                  end
                  ST_DIVM: state_in = ST_DATE;
                  ST_DIVH: begin
                     hh_in    = qfull[4:0];
                     drem_in  = 12'(st.rem[11:6]);
                     dsh_in   = {st.rem[5:0], 3'd0};
                     dcnt_in  = '0;
                     state_in = ST_DIVMI;
                  end
                  default: begin
                     mi_in    = qfull[5:0];
                     ss_in    = st.rem[5:0];
                     ycnt_in  = '0;
                     state_in = ST_YDIG;
                  end
               endcase
            end
         end
         ST_YOEP: begin
            drem_in  = 12'(num[17:9]);
            dsh_in   = num[8:0];
            dcnt_in  = '0;
            state_in = ST_DIVY;
         end
         ST_DOY: begin
            doy_in   = doy_w[8:0];
            state_in = ST_MPP;
         end
         ST_MPP: begin
            drem_in  = 12'(mpn[10:6]);
            dsh_in   = {mpn[5:0], 3'd0};
            dcnt_in  = '0;
            state_in = ST_DIVM;
         end
         ST_DATE: begin
            day_in   = day_w[4:0];
            mon_in   = mon_c;
            yval_in  = 14'(yoe_ff) + 14'(era_ff) * 14'd400 + 14'(mon_c <= 4'd2);
            drem_in  = 12'(tod_ff[16:6]);
            dsh_in   = {tod_ff[5:0], 3'd0};
            dcnt_in  = '0;
            state_in = ST_DIVH;
         end
         ST_YDIG: begin
            ydig_in = {ydig_ff[11:0], yld.dig};
            yval_in = 14'(yld.rest * 30'd10);
            ycnt_in = ycnt_ff + 2'd1;
            if (ycnt_ff == YDIG_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: ;
      endcase

      if (take) begin
         days_in  = in_item.days;
         tod_in   = in_item.tod;
         fval_in  = in_item.frac;
         fcnt_in  = '0;
         state_in = ST_ERA;
      end
   end

   assign out_text = {
      dchar(ydig_ff[15:12]), dchar(ydig_ff[11:8]), dchar(ydig_ff[7:4]), dchar(ydig_ff[3:0]),
      CH_DASH, two_chars(7'(mon_ff)), CH_DASH, two_chars(7'(day_ff)),
      CH_T, two_chars(7'(hh_ff)), CH_COLON, two_chars(7'(mi_ff)),
      CH_COLON, two_chars(7'(ss_ff)), CH_DOT,
      dchar(fdig_ff[35:32]), dchar(fdig_ff[31:28]), dchar(fdig_ff[27:24]),
      dchar(fdig_ff[23:20]), dchar(fdig_ff[19:16]), dchar(fdig_ff[15:12]),
      dchar(fdig_ff[11:8]), dchar(fdig_ff[7:4]), dchar(fdig_ff[3:0]),
      CH_Z
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dcnt_ff  <= '0;
         ycnt_ff  <= '0;
         fcnt_ff  <= FRAC_DONE;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
         ycnt_ff  <= ycnt_in;
         fcnt_ff  <= fcnt_in;
      end
      days_ff <= days_in;
      tod_ff  <= tod_in;
      era_ff  <= era_in;
      doe_ff  <= doe_in;
      yoe_ff  <= yoe_in;
      doy_ff  <= doy_in;
      drem_ff <= drem_in;
      dsh_ff  <= dsh_in;
      yval_ff <= yval_in;
      ydig_ff <= ydig_in;
      mon_ff  <= mon_in;
      day_ff  <= day_in;
      hh_ff   <= hh_in;
      mi_ff   <= mi_in;
      ss_ff   <= ss_in;
      fval_ff <= fval_in;
      fdig_ff <= fdig_in;
   end

endmodule

// ===== sv/ert_emit.sv =====
// Output stage: shift the text line out one character per rsp_valid/rsp_ready handshake.
module ert_emit import ert_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [TextBits-1:0] in_text,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CharBits-1:0] rsp_text_char,
   output logic                rsp_last_char
);

   localparam logic [4:0] LAST_IDX = 5'(TextLen - 1);

   logic [TextBits-1:0] text_ff, text_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                fire, fin;

   assign rsp_valid     = busy_ff;
   assign rsp_text_char = text_ff[TextBits-1 -: CharBits];
   assign rsp_last_char = (cnt_ff == LAST_IDX);
   assign fire          = rsp_valid && rsp_ready;
   assign fin           = fire && rsp_last_char;
   assign in_ready      = !busy_ff || fin;

   always_comb begin
      text_in = text_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (fire) begin
         text_in = text_ff << CharBits;
         cnt_in  = cnt_ff + 5'd1;
         if (fin) busy_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         text_in = in_text;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      text_ff <= text_in;
   end

endmodule

// ===== sv/epoch_ns_to_rfc3339_text.sv =====
// Top level: nanosecond epoch count to 30-character UTC timestamp text.
// The output stage sends one character per cycle while rsp_ready is high; the split
// divider and the calendar sequencer each take a new item only once done with the last.
// Reset is synchronous and active high; it clears control state only, no clearing pass.
module epoch_ns_to_rfc3339_text import ert_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [NsWidth-1:0]  req_epoch_nanoseconds,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CharBits-1:0] rsp_text_char,
   output logic                rsp_last_char
);

   logic                split_valid, split_ready;
   split_type           split_item;
   logic                q_valid, q_ready;
   split_type           q_item;
   logic                text_valid, text_ready;
   logic [TextBits-1:0] text;

   ert_split u_split (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_epoch_nanoseconds (req_epoch_nanoseconds),
      .out_valid             (split_valid),
      .out_ready             (split_ready),
      .out_item              (split_item)
   );

   ert_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_item   (split_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   ert_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (text_valid),
      .out_ready (text_ready),
      .out_text  (text)
   );

   ert_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (text_valid),
      .in_ready      (text_ready),
      .in_text       (text),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
